>>> rtl/assert_macros.svh
// Concurrent assertion helpers, compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Clock and reset given explicitly.
`define PFP_ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Module default clock and reset.
`define PFP_ASSERT_DEF(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`else
`define PFP_ASSERT_CLK(label, clk, rstn, prop, msg)
`define PFP_ASSERT_DEF(label, prop, msg)
`endif

`endif

>>> rtl/pfp_pkg.sv
package pfp_pkg;

  localparam int unsigned CNT_W   = 5;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned COORD_W = 8;
  localparam int unsigned PT_W    = 2 * COORD_W;

  localparam logic [COORD_W-1:0] EOF_FLAG    = 8'h80;
  localparam logic [POS_W-1:0]   LIMIT_RESET = 16'd4096;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ODD  = 2'd1,
    ST_LONG = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    EM_IDLE,
    EM_ERR,
    EM_H0,
    EM_H1,
    EM_H2,
    EM_PX,
    EM_PY
  } emit_state_e;

  // packet or error request from frame tracking to the emitter
  typedef struct packed {
    logic             valid;
    status_e          status;
    logic [POS_W-1:0] start;
    logic [CNT_W-1:0] count;
    logic             last_pkt;
  } job_t;

endpackage

>>> rtl/pfp_point_mem.sv
module pfp_point_mem import pfp_pkg::*; #(
  parameter int unsigned MAX_POINTS = 28,
  localparam int unsigned AW = $clog2(MAX_POINTS)
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  logic [PT_W-1:0] wdata_i,
  input  logic [AW-1:0]   raddr_i,
  output logic [PT_W-1:0] rdata_o
);

  logic [PT_W-1:0] mem_q [MAX_POINTS];
  logic [PT_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/pfp_frame.sv
`include "assert_macros.svh"

module pfp_frame import pfp_pkg::*; #(
  parameter int unsigned MAX_POINTS = 28,
  localparam int unsigned AW = $clog2(MAX_POINTS)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [POS_W-1:0]   cfg_wdata_i,
  input  logic               accept_i,
  input  logic [COORD_W-1:0] x_coord_i,
  input  logic [COORD_W-1:0] y_coord_i,
  input  logic               last_point_i,
  output logic               mem_we_o,
  output logic [AW-1:0]      mem_waddr_o,
  output logic [PT_W-1:0]    mem_wdata_o,
  output job_t               job_o
);

  localparam logic [CNT_W-1:0] MaxCnt  = CNT_W'(MAX_POINTS);
  localparam logic [POS_W-1:0] MaxStep = POS_W'(MAX_POINTS);

  logic [POS_W-1:0] limit_q, limit_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic             ovf_q, ovf_d;

  logic [POS_W:0]   taken_sum;
  logic             take;
  logic [CNT_W-1:0] fill_inc;
  logic             odd;
  logic             drop;
  logic             frame_close;

  assign frame_close = accept_i & last_point_i;

  always_comb begin
    taken_sum = {1'b0, pos_q} + (POS_W + 1)'(fill_q);
    take      = taken_sum < {1'b0, limit_q};
    fill_inc  = fill_q + CNT_W'(take);
    odd       = pos_q[0] ^ fill_inc[0];
    drop      = ovf_q | ~take;

    limit_d = cfg_we_i ? cfg_wdata_i : limit_q;
    pos_d   = pos_q;
    fill_d  = fill_q;
    ovf_d   = ovf_q;

    job_o          = '0;
    job_o.status   = ST_OK;
    job_o.start    = pos_q;
    job_o.count    = fill_inc;

    if (accept_i) begin
      if (frame_close) begin
        job_o.valid    = drop | odd | (fill_inc != '0);
        job_o.last_pkt = 1'b1;
        if (drop) begin
          job_o.status = ST_LONG;
        end else if (odd) begin
          job_o.status = ST_ODD;
        end
        pos_d  = '0;
        fill_d = '0;
        ovf_d  = 1'b0;
      end else if (fill_inc == MaxCnt) begin
        job_o.valid = 1'b1;
        pos_d       = pos_q + MaxStep;
        fill_d      = '0;
      end else begin
        fill_d = fill_inc;
        ovf_d  = drop;
      end
    end
  end

  assign mem_we_o    = accept_i & take;
  assign mem_waddr_o = fill_q[AW-1:0];
  assign mem_wdata_o = {x_coord_i, y_coord_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
      pos_q   <= '0;
      fill_q  <= '0;
      ovf_q   <= 1'b0;
    end else begin
      limit_q <= limit_d;
      pos_q   <= pos_d;
      fill_q  <= fill_d;
      ovf_q   <= ovf_d;
    end
  end

  `PFP_ASSERT_CLK(a_fill_bound, clk_i, rst_ni, fill_q < MaxCnt, "chunk fill reached capacity")
  `PFP_ASSERT_CLK(a_close_fill, clk_i, rst_ni, frame_close |=> fill_q == '0 && !ovf_q, "fill kept")
  `PFP_ASSERT_CLK(a_close_pos, clk_i, rst_ni, frame_close |=> pos_q == '0, "position kept")
  `PFP_ASSERT_CLK(a_job_accept, clk_i, rst_ni, job_o.valid |-> accept_i, "request without point")

endmodule

>>> rtl/pfp_emit.sv
`include "assert_macros.svh"

module pfp_emit import pfp_pkg::*; #(
  parameter int unsigned MAX_POINTS = 28,
  localparam int unsigned AW = $clog2(MAX_POINTS)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  job_t               job_i,
  output logic               idle_o,
  output logic [AW-1:0]      raddr_o,
  input  logic [PT_W-1:0]    rdata_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [COORD_W-1:0] data_byte_o,
  output logic               packet_start_o,
  output logic               packet_end_o,
  output logic [1:0]         status_o
);

  emit_state_e state_q, state_d;

  logic [POS_W-1:0]   start_q, start_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               last_pkt_q, last_pkt_d;
  status_e            err_q, err_d;
  logic [CNT_W-1:0]   rd_cnt_q, rd_cnt_d;
  logic [COORD_W-1:0] hold_y_q, hold_y_d;

  logic               out_valid_q, out_valid_d;
  logic [COORD_W-1:0] out_data_q, out_data_d;
  logic               out_start_q, out_start_d;
  logic               out_end_q, out_end_d;
  status_e            out_status_q, out_status_d;

  logic out_load;
  logic emit;

  always_comb begin
    out_load = ~out_valid_q | out_ready_i;
    emit     = 1'b0;

    state_d    = state_q;
    start_d    = start_q;
    cnt_d      = cnt_q;
    last_pkt_d = last_pkt_q;
    err_d      = err_q;
    rd_cnt_d   = rd_cnt_q;
    hold_y_d   = hold_y_q;

    out_data_d   = out_data_q;
    out_start_d  = 1'b0;
    out_end_d    = 1'b0;
    out_status_d = ST_OK;

    unique case (state_q)
      EM_IDLE: begin
        if (job_i.valid) begin
          start_d    = job_i.start;
          cnt_d      = job_i.count;
          last_pkt_d = job_i.last_pkt;
          err_d      = job_i.status;
          rd_cnt_d   = '0;
          state_d    = (job_i.status == ST_OK) ? EM_H0 : EM_ERR;
        end
      end
      EM_ERR: begin
        if (out_load) begin
          emit         = 1'b1;
          out_data_d   = '0;
          out_end_d    = 1'b1;
          out_status_d = err_q;
          state_d      = EM_IDLE;
        end
      end
      EM_H0: begin
        if (out_load) begin
          emit        = 1'b1;
          out_data_d  = start_q[POS_W-1:COORD_W];
          out_start_d = 1'b1;
          state_d     = EM_H1;
        end
      end
      EM_H1: begin
        if (out_load) begin
          emit       = 1'b1;
          out_data_d = start_q[COORD_W-1:0];
          state_d    = EM_H2;
        end
      end
      EM_H2: begin
        if (out_load) begin
          emit       = 1'b1;
          out_data_d = COORD_W'(cnt_q) | (last_pkt_q ? EOF_FLAG : '0);
          state_d    = EM_PX;
        end
      end
      EM_PX: begin
        if (out_load) begin
          emit       = 1'b1;
          out_data_d = rdata_i[PT_W-1:COORD_W];
          hold_y_d   = rdata_i[COORD_W-1:0];
          rd_cnt_d   = rd_cnt_q + 1'b1;
          state_d    = EM_PY;
        end
      end
      EM_PY: begin
        if (out_load) begin
          emit       = 1'b1;
          out_data_d = hold_y_q;
          out_end_d  = (rd_cnt_q == cnt_q);
          state_d    = (rd_cnt_q == cnt_q) ? EM_IDLE : EM_PX;
        end
      end
      default: begin
        state_d = EM_IDLE;
      end
    endcase

    out_valid_d = emit | (out_valid_q & ~out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= EM_IDLE;
      out_valid_q <= 1'b0;
      rd_cnt_q    <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      rd_cnt_q    <= rd_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q    <= start_d;
    cnt_q      <= cnt_d;
    last_pkt_q <= last_pkt_d;
    err_q      <= err_d;
    hold_y_q   <= hold_y_d;
    if (emit) begin
      out_data_q   <= out_data_d;
      out_start_q  <= out_start_d;
      out_end_q    <= out_end_d;
      out_status_q <= out_status_d;
    end
  end

  assign idle_o         = (state_q == EM_IDLE);
  assign raddr_o        = rd_cnt_q[AW-1:0];
  assign out_valid_o    = out_valid_q;
  assign data_byte_o    = out_data_q;
  assign packet_start_o = out_start_q;
  assign packet_end_o   = out_end_q;
  assign status_o       = out_status_q;

  `PFP_ASSERT_DEF(a_job_when_idle, job_i.valid |-> state_q == EM_IDLE, "request while emitter busy")
  `PFP_ASSERT_DEF(a_px_then_py, (state_q == EM_PX && out_load) |=> state_q == EM_PY, "x byte not followed by y byte")
  `PFP_ASSERT_DEF(a_start_ok, (out_valid_q && out_start_q) |-> out_status_q == ST_OK, "packet start on error result")
  `PFP_ASSERT_DEF(a_rd_bound, (state_q == EM_PX || state_q == EM_PY) |-> rd_cnt_q <= cnt_q, "read pointer past chunk")

endmodule

>>> rtl/point_frame_packetizer_top.sv
// A point that closes or fills a chunk shows its first result after the emitter state and output
// registers; one that causes no result keeps in_ready_o high. in_ready_o drops while the emitter
// sends a packet of 3 + 2*n bytes (n buffered points), one byte per cycle while out_ready_i is
// high, or one error result. Point bytes use the chunk memory's single registered read port.
// Reset: frame state and handshakes cleared, frame_limit = 4096; chunk memory not cleared.
module point_frame_packetizer_top import pfp_pkg::*; #(
  parameter int unsigned MAX_POINTS = 28
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [POS_W-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [COORD_W-1:0] x_coord_i,
  input  logic [COORD_W-1:0] y_coord_i,
  input  logic               last_point_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [COORD_W-1:0] data_byte_o,
  output logic               packet_start_o,
  output logic               packet_end_o,
  output logic [1:0]         status_o
);

  localparam int unsigned AW = $clog2(MAX_POINTS);

  logic            accept;
  logic            idle;
  job_t            job;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [PT_W-1:0] mem_wdata;
  logic [AW-1:0]   mem_raddr;
  logic [PT_W-1:0] mem_rdata;

  assign in_ready_o = idle;
  assign accept     = in_valid_i & idle;

  pfp_frame #(
    .MAX_POINTS(MAX_POINTS)
  ) u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .accept_i     (accept),
    .x_coord_i    (x_coord_i),
    .y_coord_i    (y_coord_i),
    .last_point_i (last_point_i),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .job_o        (job)
  );

  pfp_point_mem #(
    .MAX_POINTS(MAX_POINTS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  pfp_emit #(
    .MAX_POINTS(MAX_POINTS)
  ) u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_i          (job),
    .idle_o         (idle),
    .raddr_o        (mem_raddr),
    .rdata_i        (mem_rdata),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .data_byte_o    (data_byte_o),
    .packet_start_o (packet_start_o),
    .packet_end_o   (packet_end_o),
    .status_o       (status_o)
  );

endmodule
